@@ hw/rtl/wis_pkg.sv @@
// Shared types and constants for the weighted index sampler.
// Field widths, command codes, controller states and the result beat type.
// No dependencies.
package wis_pkg;

	localparam int NUM_ANGLES_DEF = 256;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 8;
	localparam int WGT_W   = 16;
	localparam int U_W     = 16;
	localparam int ENTRY_W = 24;
	localparam int TOTAL_W = 32;
	localparam int TGT_W   = U_W + TOTAL_W;
	localparam int SCALE_W = ENTRY_W + U_W;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_WR,
		ST_ACC_TOT,
		ST_DRAW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] angle;
	} res_t;

endpackage

@@ hw/rtl/wis_mem.sv @@
// Weight table storage: one write port, one read port, registered read data.
// Uses nothing from the package.
module wis_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/wis_ctrl.sv @@
// Sequencer and datapath: clearing pass, read-modify-write accumulate, draw walk.
// Depends on wis_pkg; drives the table memory ports of wis_mem.
module wis_ctrl #(
	parameter int NUM_ANGLES = wis_pkg::NUM_ANGLES_DEF,
	parameter int AW         = $clog2(NUM_ANGLES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [wis_pkg::CMD_W-1:0]   command,
	input  logic [wis_pkg::IDX_W-1:0]   angle_index,
	input  logic [wis_pkg::WGT_W-1:0]   weight,
	input  logic [wis_pkg::U_W-1:0]     uniform_value,
	output wis_pkg::res_t               res_d,
	output logic                        res_load,
	input  logic                        res_free,
	output logic                        mem_rd_en,
	output logic [AW-1:0]               mem_rd_addr,
	input  logic [wis_pkg::ENTRY_W-1:0] mem_rd_data,
	output logic                        mem_wr_en,
	output logic [AW-1:0]               mem_wr_addr,
	output logic [wis_pkg::ENTRY_W-1:0] mem_wr_data
);

	import wis_pkg::*;

	localparam int CW   = AW + 1;
	localparam int IXW  = (AW > IDX_W) ? AW : IDX_W;
	localparam int ACCW = AW + SCALE_W;
	localparam int CMPW = (ACCW > TGT_W) ? ACCW : TGT_W;

	state_t state_q, state_d;

	logic [CW-1:0]      cnt_q;
	logic               v_s1, v_s2, v_s3;
	logic [TOTAL_W-1:0] total_q;

	logic [AW-1:0]      addr_q;
	logic [WGT_W-1:0]   w_q;
	logic [ENTRY_W-1:0] gain_q;
	logic [TGT_W-1:0]   target_q;
	logic [ACCW-1:0]    acc_q;
	logic               found_q;
	logic [IDX_W-1:0]   pick_q;
	logic [AW-1:0]      idx_s1, idx_s2, idx_s3;
	logic [SCALE_W-1:0] es_s2;
	logic               nz_s2, chk_s3, last_s3;

	logic               cmd_take;
	logic [IXW-1:0]     idx_w;
	logic               in_range;
	logic               clr_last;
	logic               issuing;
	logic               hit;
	logic               end_miss;
	logic               draw_stop;
	logic               run;
	logic [ENTRY_W-1:0] room;
	logic [ENTRY_W-1:0] w24;
	logic [ENTRY_W-1:0] gained;
	logic [TOTAL_W:0]   tot_sum;
	logic [SCALE_W-1:0] es;
	logic [TGT_W-1:0]   prod;
	logic [IXW-1:0]     pick_w;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd_valid && cmd_ready;
	assign idx_w     = IXW'(angle_index);
	assign in_range  = 32'(angle_index) < 32'(NUM_ANGLES);
	assign clr_last  = (cnt_q == CW'(NUM_ANGLES - 1));

	assign hit       = v_s3 && chk_s3 && (CMPW'(target_q) <= CMPW'(acc_q));
	assign end_miss  = v_s3 && last_s3 && !hit;
	assign draw_stop = hit || end_miss;
	assign run       = (state_q == ST_DRAW) && !draw_stop;
	assign issuing   = run && (cnt_q < CW'(NUM_ANGLES));

	assign room    = ~mem_rd_data;
	assign w24     = ENTRY_W'(w_q);
	assign gained  = (w24 > room) ? room : w24;
	assign tot_sum = {1'b0, total_q} + (TOTAL_W + 1)'(gain_q);
	assign es      = {mem_rd_data, {U_W{1'b0}}} - SCALE_W'(mem_rd_data);
	assign prod    = TGT_W'(uniform_value) * TGT_W'(total_q);
	assign pick_w  = IXW'(idx_s3);

	always_comb begin
		state_d     = state_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = idx_w[AW-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_q;
		mem_wr_data = mem_rd_data + gained;
		res_load    = 1'b0;
		res_d.found = found_q;
		res_d.angle = pick_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = cnt_q[AW-1:0];
				mem_wr_data = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_take) begin
					unique case (command)
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_ACC: begin
							if (in_range) begin
								mem_rd_en = 1'b1;
								state_d   = ST_ACC_WR;
							end
						end
						CMD_DRAW: state_d = (total_q == '0) ? ST_DONE : ST_DRAW;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACC_WR: begin
				mem_wr_en = 1'b1;
				state_d   = ST_ACC_TOT;
			end
			ST_ACC_TOT: state_d = ST_IDLE;
			ST_DRAW: begin
				mem_rd_en   = issuing;
				mem_rd_addr = cnt_q[AW-1:0];
				if (draw_stop) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issuing;
			v_s2    <= v_s1 && run;
			v_s3    <= v_s2 && run;
			unique case (state_q)
				ST_CLEAR: cnt_q <= clr_last ? '0 : cnt_q + CW'(1);
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd_take && command == CMD_CLEAR) begin
						total_q <= '0;
					end
				end
				ST_ACC_TOT: total_q <= tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
				ST_DRAW: begin
					if (issuing) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_ACC_WR, ST_DONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[AW-1:0];
		idx_s2  <= idx_s1;
		es_s2   <= es;
		nz_s2   <= (mem_rd_data != '0);
		idx_s3  <= idx_s2;
		chk_s3  <= nz_s2;
		last_s3 <= (idx_s2 == AW'(NUM_ANGLES - 1));
		gain_q  <= gained;
		if (cmd_take) begin
			addr_q   <= idx_w[AW-1:0];
			w_q      <= weight;
			target_q <= prod;
			acc_q    <= '0;
			found_q  <= 1'b0;
			pick_q   <= '0;
		end else if (state_q == ST_DRAW) begin
			if (v_s2 && nz_s2) begin
				acc_q <= acc_q + ACCW'(es_s2);
			end
			if (hit) begin
				found_q <= 1'b1;
				pick_q  <= pick_w[IDX_W-1:0];
			end
		end
	end

endmodule

@@ hw/rtl/weighted_index_sampler_core.sv @@
// Weighted index sampler top level: table memory, sequencer and result register.
// Depends on wis_pkg, wis_mem and wis_ctrl.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+--------------------------------------------------
//   cmd     | cmd_valid | cmd_ready | command, angle_index, weight, uniform_value
//   res     | res_valid | res_ready | chosen_angle, found (one beat per draw command)
//
// Reset and every clear command run a clearing pass over all NUM_ANGLES entries, one entry
// per cycle through the memory write port; no cmd beat is taken meanwhile.
// Accumulate runs a read, a write back and a total update in turn.
// A draw walks the table through the single read port, one entry per cycle, until the
// first hit or the last entry; it goes straight to the result when the total is zero.
// A waiting res beat sits in the output register; the sequencer holds a finished
// draw only while that register is still full and res_ready is low.
module weighted_index_sampler_core #(
	parameter int NUM_ANGLES = wis_pkg::NUM_ANGLES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [wis_pkg::CMD_W-1:0] command,
	input  logic [wis_pkg::IDX_W-1:0] angle_index,
	input  logic [wis_pkg::WGT_W-1:0] weight,
	input  logic [wis_pkg::U_W-1:0]   uniform_value,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [wis_pkg::IDX_W-1:0] chosen_angle,
	output logic                      found
);

	import wis_pkg::*;

	localparam int AW = $clog2(NUM_ANGLES);

	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	logic [ENTRY_W-1:0] mem_rd_data;
	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic [ENTRY_W-1:0] mem_wr_data;

	res_t res_d;
	res_t res_q;
	logic res_load;
	logic res_free;
	logic res_valid_q;

	wis_mem #(
		.DEPTH (NUM_ANGLES),
		.AW    (AW),
		.DW    (ENTRY_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	wis_ctrl #(
		.NUM_ANGLES (NUM_ANGLES),
		.AW         (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.command       (command),
		.angle_index   (angle_index),
		.weight        (weight),
		.uniform_value (uniform_value),
		.res_d         (res_d),
		.res_load      (res_load),
		.res_free      (res_free),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data)
	);

	assign res_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign chosen_angle = res_q.angle;
	assign found        = res_q.found;

endmodule
